/* sv/difference_equation_controller_core_macros.svh */
// Assertion macros for the difference equation controller core.
// Used by the top level only; needs no package.
`ifndef DIFFERENCE_EQUATION_CONTROLLER_CORE_MACROS_SVH
`define DIFFERENCE_EQUATION_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEC_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("controller check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define DEC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("controller check failed one cycle later");

`endif

/* sv/dec_pkg.sv */
// Shared types and constants for the difference equation controller.
// No dependencies.
package dec_pkg;

    localparam int NUM_TAPS      = 4;
    localparam int DEN_TAPS      = 3;
    localparam int NUM_COEF_REGS = 4;
    localparam int DEN_COEF_REGS = 3;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int LIMIT_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = COEF_W;
    localparam int FRAC_BITS = 13;

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS + DEN_TAPS) + 1;
    localparam int Y_W    = ACC_W - FRAC_BITS;

    localparam logic [ACC_W-1:0]   ROUND_BIAS  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COEF_0,
        REG_NUM_COEF_1,
        REG_NUM_COEF_2,
        REG_NUM_COEF_3,
        REG_DEN_COEF_1,
        REG_DEN_COEF_2,
        REG_DEN_COEF_3,
        REG_OUTPUT_LIMIT
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_COEF_REGS-1:0][COEF_W-1:0] num;
        logic [DEN_COEF_REGS-1:0][COEF_W-1:0] den;
        logic [LIMIT_W-1:0]                   limit;
    } coef_set_t;

endpackage

/* sv/difference_equation_controller_core.sv */
// Top level of the difference equation controller: stream ports, input
// register, result register. Depends on dec_pkg, dec_coef_regs, dec_filter.
//
// Each accepted error sample produces one control value
// u(k) = sum b_j*e(k-j) - sum a_j*u(k-j), rounded from Q.28 to Q1.15 and
// clipped to +/- output_limit; m_tuser flags a clipped result. The block
// takes one item per clock cycle while the output is not stalled. An accepted
// item is written into the input register; its result goes into the result
// register when the output side is free, raising m_tvalid, and a stalled
// output holds the item in the input register. Between the two registers lies
// a combinational datapath: seven parallel products, one adder tree,
// rounding and the clip, with the clipped value fed straight back into the
// output history. The user must write coefficients and the limit through the
// cfg port while no item is in flight; the block itself does not enforce it.
`include "difference_equation_controller_core_macros.svh"

module difference_equation_controller_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] error_sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [15:0] control_value
    output logic [0:0]                     m_tuser,   // [0] saturated
    input  logic                           cfg_we,
    input  logic [dec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dec_pkg::*;

    coef_set_t                  coefs;
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic                       out_sat_reg;
    logic                       out_ready;
    logic                       step;
    logic signed [SAMPLE_W-1:0] result_value;
    logic                       result_sat;

    dec_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coefs     (coefs)
    );

    dec_filter u_filter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .sample        (in_sample_reg),
        .coefs         (coefs),
        .control_value (result_value),
        .saturated     (result_sat)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
        end
        if (step) begin
            out_value_reg <= result_value;
            out_sat_reg   <= result_sat;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_sat_reg;

    `DEC_ASSERT_SAME(a_empty_stage_ready, aclk, aresetn, !in_valid_reg, s_tready)
    `DEC_ASSERT_NEXT(a_step_fills_result, aclk, aresetn, step, m_tvalid)
    `DEC_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn, s_tvalid && s_tready, in_valid_reg)

endmodule

/* sv/dec_coef_regs.sv */
// Coefficient and limit register file written through the config port.
// Depends on dec_pkg.
module dec_coef_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [dec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output dec_pkg::coef_set_t          coefs
);
    import dec_pkg::*;

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb begin
        coefs_next = coefs_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_COEF_0:   coefs_next.num[0] = cfg_wdata;
                REG_NUM_COEF_1:   coefs_next.num[1] = cfg_wdata;
                REG_NUM_COEF_2:   coefs_next.num[2] = cfg_wdata;
                REG_NUM_COEF_3:   coefs_next.num[3] = cfg_wdata;
                REG_DEN_COEF_1:   coefs_next.den[0] = cfg_wdata;
                REG_DEN_COEF_2:   coefs_next.den[1] = cfg_wdata;
                REG_DEN_COEF_3:   coefs_next.den[2] = cfg_wdata;
                REG_OUTPUT_LIMIT: coefs_next.limit  = cfg_wdata[LIMIT_W-1:0];
                default:          coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.num   <= '0;
            coefs_reg.den   <= '0;
            coefs_reg.limit <= LIMIT_RESET;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

/* sv/dec_filter.sv */
// Difference equation datapath: products, sum, rounding, clipping and the
// error and output histories. Depends on dec_pkg.
module dec_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic signed [dec_pkg::SAMPLE_W-1:0] sample,
    input  dec_pkg::coef_set_t                 coefs,
    output logic signed [dec_pkg::SAMPLE_W-1:0] control_value,
    output logic                               saturated
);
    import dec_pkg::*;

    localparam int ERR_D = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;

    logic signed [SAMPLE_W-1:0] err_hist_reg [ERR_D];
    logic signed [SAMPLE_W-1:0] out_hist_reg [DEN_TAPS];
    logic signed [SAMPLE_W-1:0] tap_e        [NUM_TAPS];
    logic signed [PROD_W-1:0]   prod_num     [NUM_TAPS];
    logic signed [PROD_W-1:0]   prod_den     [DEN_TAPS];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [Y_W-1:0]      y_full;
    logic signed [Y_W-1:0]      lim_pos;
    logic signed [Y_W-1:0]      lim_neg;
    logic signed [Y_W-1:0]      y_clip;

    assign tap_e[0] = sample;

    genvar j;
    generate
        for (j = 1; j < NUM_TAPS; j++) begin : g_tap
            assign tap_e[j] = err_hist_reg[j-1];
        end
        // Taps past the written registers carry a fixed zero weight.
        for (j = 0; j < NUM_TAPS; j++) begin : g_num
            if (j < NUM_COEF_REGS) begin : g_mul
                assign prod_num[j] = $signed(coefs.num[j]) * tap_e[j];
            end else begin : g_zero
                assign prod_num[j] = '0;
            end
        end
        for (j = 0; j < DEN_TAPS; j++) begin : g_den
            if (j < DEN_COEF_REGS) begin : g_mul
                assign prod_den[j] = $signed(coefs.den[j]) * out_hist_reg[j];
            end else begin : g_zero
                assign prod_den[j] = '0;
            end
        end
    endgenerate

    always_comb begin
        acc = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            acc = acc + ACC_W'(prod_num[k]);
        end
        for (int k = 0; k < DEN_TAPS; k++) begin
            acc = acc - ACC_W'(prod_den[k]);
        end
    end

    // Round half toward plus infinity, then drop the fraction with floor.
    assign acc_rnd = acc + $signed(ROUND_BIAS);
    assign y_full  = Y_W'(acc_rnd >>> FRAC_BITS);
    assign lim_pos = Y_W'($signed({1'b0, coefs.limit}));
    assign lim_neg = -lim_pos;

    always_comb begin
        y_clip    = y_full;
        saturated = 1'b0;
        if (y_full > lim_pos) begin
            y_clip    = lim_pos;
            saturated = 1'b1;
        end else if (y_full < lim_neg) begin
            y_clip    = lim_neg;
            saturated = 1'b1;
        end
    end

    assign control_value = y_clip[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ERR_D; k++) begin
                err_hist_reg[k] <= '0;
            end
            for (int k = 0; k < DEN_TAPS; k++) begin
                out_hist_reg[k] <= '0;
            end
        end else if (step) begin
            err_hist_reg[0] <= sample;
            for (int k = 1; k < ERR_D; k++) begin
                err_hist_reg[k] <= err_hist_reg[k-1];
            end
            out_hist_reg[0] <= control_value;
            for (int k = 1; k < DEN_TAPS; k++) begin
                out_hist_reg[k] <= out_hist_reg[k-1];
            end
        end
    end

endmodule

/* test/difference_equation_controller_checker.sv */
// Checker for the difference equation controller: watches both stream channels and the
// register port, predicts every control value and compares it with the block's output.
// Depends on dec_pkg only.
module difference_equation_controller_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,
    input  logic [0:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [dec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dec_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] control_value;
        logic                       saturated;
    } control_result_t;

    logic signed [COEF_W-1:0]   b_gain [NUM_COEF_REGS];
    logic signed [COEF_W-1:0]   a_gain [DEN_COEF_REGS];
    logic [LIMIT_W-1:0]         clip_limit;
    logic signed [SAMPLE_W-1:0] past_error [NUM_TAPS-1];
    logic signed [SAMPLE_W-1:0] past_control [DEN_TAPS];
    control_result_t            expected_controls [$];

    // Full-precision sum of products, rounded half up from Q.28 to Q.15, then clipped.
    function automatic control_result_t predict_control(input logic signed [SAMPLE_W-1:0] err);
        longint          acc;
        longint          y;
        longint          lim;
        control_result_t r;
        acc = longint'(b_gain[0]) * longint'(err);
        for (int j = 1; j < NUM_TAPS; j++) begin
            acc += longint'(b_gain[j]) * longint'(past_error[j-1]);
        end
        for (int j = 0; j < DEN_TAPS; j++) begin
            acc -= longint'(a_gain[j]) * longint'(past_control[j]);
        end
        y   = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        lim = longint'(clip_limit);
        r.saturated = 1'b0;
        if (y > lim) begin
            y = lim;
            r.saturated = 1'b1;
        end else if (y < -lim) begin
            y = -lim;
            r.saturated = 1'b1;
        end
        r.control_value = y[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        control_result_t want;
        if (!aresetn) begin
            foreach (b_gain[j]) b_gain[j] = '0;
            foreach (a_gain[j]) a_gain[j] = '0;
            foreach (past_error[j]) past_error[j] = '0;
            foreach (past_control[j]) past_control[j] = '0;
            clip_limit = LIMIT_RESET;
            expected_controls.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index <= REG_NUM_COEF_3) begin
                    b_gain[cfg_index] = cfg_wdata;
                end else if (cfg_index <= REG_DEN_COEF_3) begin
                    a_gain[cfg_index - REG_DEN_COEF_1] = cfg_wdata;
                end else begin
                    clip_limit = cfg_wdata[LIMIT_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_controls.size() == 0) begin
                    $error("control_value: expected none, actual %0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    want = expected_controls.pop_front();
                    if (m_tdata !== want.control_value) begin
                        $error("control_value: expected %0d, actual %0d",
                               want.control_value, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_control(s_tdata);
                expected_controls.push_back(want);
                for (int j = NUM_TAPS - 2; j > 0; j--) past_error[j] = past_error[j-1];
                past_error[0] = s_tdata;
                for (int j = DEN_TAPS - 1; j > 0; j--) past_control[j] = past_control[j-1];
                past_control[0] = want.control_value;
            end
        end
        pending = expected_controls.size();
    end

endmodule

/* test/tb_difference_equation_controller_core.sv */
// Testbench top for the difference equation controller core: clock, reset, error sample
// stimulus, register writes, result back-pressure and the verdict.
// Depends on dec_pkg, the core and difference_equation_controller_checker.
module tb_difference_equation_controller_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dec_pkg::*;

    localparam int IDLE_PCT        = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_AFTER      = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 250;

    typedef enum {GAINS_FULL, GAINS_STABLE, GAINS_EXTREME} gain_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    bit calm         = 1'b0;
    int stall_cycles = 0;
    int rx_count     = 0;
    int hold_left    = 0;
    bit held         = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    difference_equation_controller_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    difference_equation_controller_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // All tasks are entered and left at a falling edge.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Registers are only rewritten once every control value in flight has come out.
    task automatic set_gains(input logic [CFG_DATA_W-1:0] b0, b1, b2, b3, a1, a2, a3, lim);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(REG_NUM_COEF_0, b0);
        write_reg(REG_NUM_COEF_1, b1);
        write_reg(REG_NUM_COEF_2, b2);
        write_reg(REG_NUM_COEF_3, b3);
        write_reg(REG_DEN_COEF_1, a1);
        write_reg(REG_DEN_COEF_2, a2);
        write_reg(REG_DEN_COEF_3, a3);
        write_reg(REG_OUTPUT_LIMIT, lim);
    endtask

    task automatic send_error(input logic [15:0] value);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_error();
        int v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = int'($urandom_range(1024)) - 512;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    // Stable gains keep the sum of the feedback weights below one so that the
    // output history stays away from the clip most of the time.
    function automatic logic [CFG_DATA_W-1:0] rand_gain(input gain_mode_t mode, input bit feedback);
        int v;
        case (mode)
            GAINS_STABLE: begin
                if (feedback) v = int'($urandom_range(4096)) - 2048;
                else          v = int'($urandom_range(16384)) - 8192;
            end
            GAINS_EXTREME: v = $urandom_range(1) ? 131071 : -131072;
            default:       v = $urandom;
        endcase
        return v[CFG_DATA_W-1:0];
    endfunction

    // Bits above the limit field are filled at random; the block ignores them.
    function automatic logic [CFG_DATA_W-1:0] rand_limit();
        logic [CFG_DATA_W-1:0] w;
        w = $urandom;
        case ($urandom_range(5))
            0:       w[LIMIT_W-1:0] = '0;
            1:       w[LIMIT_W-1:0] = '1;
            default: w[LIMIT_W-1:0] = $urandom_range(32767);
        endcase
        return w;
    endfunction

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) rx_count++;
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left--;
        end else if (!held && rx_count >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            m_tready  = 1'b0;
        end else begin
            m_tready  = calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        gain_mode_t mode;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset gains are zero, so even full-scale errors give zero.
        send_error(16'h7FFF);
        send_error(16'h8000);

        // Unity gain: output equals the error, and the most negative error clips.
        set_gains(18'sd8192, '0, '0, '0, '0, '0, '0, 18'd32767);
        send_error(16'h7FFF);
        send_error(16'h8000);
        send_error(16'h0000);
        send_error(16'h0001);
        send_error(16'hFFFF);

        // Largest gains with a zero limit; the limit write carries junk upper bits.
        set_gains(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                  18'h20000, 18'h20000, 18'h20000, {3'b111, 15'd0});
        send_error(16'h7FFF);
        send_error(16'h8000);
        send_error(16'h7FFF);
        send_error(16'h0000);

        // Half gain: exact hits on the limit, one past it, and rounding of halves.
        set_gains(18'sd4096, '0, '0, '0, '0, '0, '0, 18'd1000);
        send_error(16'sd2000);
        send_error(16'sd2002);
        send_error(-16'sd2000);
        send_error(-16'sd2002);
        send_error(16'sd1);
        send_error(-16'sd1);
        send_error(16'sd3);
        send_error(-16'sd3);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p == 3) ? GAINS_STABLE : gain_mode_t'(p % 3);
            set_gains(rand_gain(mode, 1'b0), rand_gain(mode, 1'b0),
                      rand_gain(mode, 1'b0), rand_gain(mode, 1'b0),
                      rand_gain(mode, 1'b1), rand_gain(mode, 1'b1),
                      rand_gain(mode, 1'b1), rand_limit());
            calm = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_error(rand_error());
            end
            calm = 1'b0;
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* difference_equation_controller_core.f */
+incdir+sv
sv/dec_pkg.sv
sv/dec_coef_regs.sv
sv/dec_filter.sv
sv/difference_equation_controller_core.sv
test/difference_equation_controller_checker.sv
test/tb_difference_equation_controller_core.sv
